// ===== sv/lphl_pkg.sv =====
// Package for the linear-probe hash lookup unit.
// Holds sizes, codes and the transfer and slot types; used by the top level and the bench.
`default_nettype none

package lphl_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SIZE_LOG2_MAX = $clog2(MAX_SLOTS + 1) - 1;

  localparam int KEY_W = 64;
  localparam int VAL_W = 8;
  localparam int IDX_W = 10;
  localparam int SIZE_LOG2_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [VAL_W-1:0] EMPTY_VALUE = 8'hFF;
  localparam logic [KEY_W-1:0] EMPTY_KEY = '0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOK_PRESENT = 2'd1;

  localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = 4'd10;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] slot_index;
    logic [KEY_W-1:0] search_key;
    logic [VAL_W-1:0] slot_value;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] found_value;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

// ===== sv/lphl_slot_ram.sv =====
// Generic one-write, one-read synchronous RAM with registered read data.
// Stands alone; the lookup unit stores its slots in it.
`default_nettype none

module lphl_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 72,
  parameter int AW = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/linear_probe_hash_lookup_unit.sv =====
// Top level of the linear-probe hash lookup unit: command sequencer,
// configuration registers and slot memory. Uses lphl_pkg and lphl_slot_ram.
`default_nettype none

// After reset the unit clears every slot to the empty marker, with busy high;
// configuration writes are taken meanwhile. A command transfers when start
// is high and busy is low. A write loads its slot at once and its result
// (found = 0) strobes on done in the next cycle; busy stays low, so commands
// may follow every cycle. A lookup probes one slot per cycle through the
// memory read port, with busy high until its result strobes on done. With no
// table present a lookup strobes a miss in the next cycle. done and result
// last one cycle and cannot be held off by the receiver.
module linear_probe_hash_lookup_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire lphl_pkg::in_t                  cmd,
  output logic                                busy,
  output logic                                done,
  output lphl_pkg::out_t                      result,
  input  wire logic                           cfg_we,
  input  wire logic [lphl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lphl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import lphl_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_SLOTS - 1);

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [ADDR_W-1:0]      pos;
  logic [ADDR_W-1:0]      pos_next;
  logic [ADDR_W-1:0]      cnt;
  logic [ADDR_W-1:0]      cnt_next;
  logic [ADDR_W-1:0]      mask;
  logic [ADDR_W-1:0]      mask_next;
  logic [ADDR_W-1:0]      clr;
  logic [SIZE_LOG2_W-1:0] size_log2;
  logic                   book_present;
  logic                   done_next;
  out_t                   result_next;
  logic [KEY_W-1:0]       cmd_key;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  slot_t                  ram_wdata;
  slot_t                  rd_slot;

  logic [SIZE_LOG2_W-1:0] eff_log2;
  logic [ADDR_W-1:0]      mask_in;
  logic                   accept;
  logic                   in_range;
  logic                   slot_empty;
  logic                   slot_match;

  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);
  assign eff_log2 = (32'(size_log2) > SIZE_LOG2_MAX) ? SIZE_LOG2_W'(SIZE_LOG2_MAX) : size_log2;
  assign mask_in = ADDR_W'(((ADDR_W + 1)'(1) << eff_log2) - (ADDR_W + 1)'(1));
  assign in_range = 32'(cmd.slot_index) < 32'(MAX_SLOTS);
  assign slot_empty = (rd_slot.key == EMPTY_KEY) && (rd_slot.value == EMPTY_VALUE);
  assign slot_match = (rd_slot.key == cmd_key);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_key <= cmd.search_key;
    end
  end

  lphl_slot_ram #(
    .DEPTH(MAX_SLOTS),
    .WIDTH(SLOT_W),
    .AW(ADDR_W)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pos_next),
    .rdata(rd_slot)
  );

  always_comb begin
    state_next = state;
    pos_next = pos;
    cnt_next = cnt;
    mask_next = mask;
    done_next = 1'b0;
    result_next = '0;
    ram_we = 1'b0;
    ram_waddr = clr;
    ram_wdata = '{key: EMPTY_KEY, value: EMPTY_VALUE};
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (cmd.op == OP_WRITE) begin
            ram_we = in_range;
            ram_waddr = ADDR_W'(cmd.slot_index);
            ram_wdata = '{key: cmd.search_key, value: cmd.slot_value};
            done_next = 1'b1;
          end else if (book_present) begin
            mask_next = mask_in;
            pos_next = ADDR_W'(cmd.search_key) & mask_in;
            cnt_next = '0;
            state_next = ST_PROBE;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        priority if (slot_empty) begin
          done_next = 1'b1;
          state_next = ST_IDLE;
        end else if (slot_match) begin
          done_next = 1'b1;
          result_next = '{found: 1'b1, found_value: rd_slot.value};
          state_next = ST_IDLE;
        end else if (cnt == mask) begin
          done_next = 1'b1;
          state_next = ST_IDLE;
        end else begin
          pos_next = (pos + ADDR_W'(1)) & mask;
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      done <= 1'b0;
      size_log2 <= SIZE_LOG2_RESET;
      book_present <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      if (state == ST_CLEAR) begin
        clr <= clr + ADDR_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE_LOG2: size_log2 <= cfg_wdata[SIZE_LOG2_W-1:0];
          REG_BOOK_PRESENT: book_present <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    cnt <= cnt_next;
    mask <= mask_next;
    result <= result_next;
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.found_value == '0))
    else $error("miss carries a nonzero value");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.op == OP_WRITE) |=> (done && !result.found))
    else $error("write transfer without a result next cycle");

  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (!done || $past(state) != ST_CLEAR))
    else $error("result strobe during clearing pass");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ((cnt & ~mask) == '0 && (pos & ~mask) == '0))
    else $error("probe position or count outside table");

  a_probe_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && state_next == ST_IDLE) |=> done)
    else $error("lookup ended without a result");

endmodule

`default_nettype wire

// ===== bench/tb_linear_probe_hash_lookup_unit.sv =====
// Testbench for linear_probe_hash_lookup_unit: directed and random command traffic,
// checked against an in-bench model of the slot table and its probe sequence.
// Depends on lphl_pkg and the unit's RTL; needs no files or arguments.
`default_nettype none

module tb_linear_probe_hash_lookup_unit;
  import lphl_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  logic                  clk;
  logic                  rst;
  logic                  start;
  in_t                   cmd;
  logic                  busy;
  logic                  done;
  out_t                  result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [KEY_W-1:0]       model_keys [MAX_SLOTS];
  logic [VAL_W-1:0]       model_vals [MAX_SLOTS];
  logic [SIZE_LOG2_W-1:0] model_size_log2;
  logic                   model_book;

  out_t             pending_results [$];
  logic [KEY_W-1:0] key_pool [$];
  out_t             exp_r;
  int               sender_idle_pct;
  int               n_sent;
  int               n_lookups;
  int               n_checked;
  int               n_hits;
  int               n_errors;
  int               cycle_count;

  linear_probe_hash_lookup_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned table_slots();
    return 1 << ((model_size_log2 > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : model_size_log2);
  endfunction

  // Apply one command to the table model and return the result it must produce.
  function automatic out_t probe_table(input in_t c);
    out_t        r;
    int unsigned size;
    int unsigned mask;
    int unsigned pos;
    int unsigned n;
    r = '0;
    if (c.op == OP_WRITE) begin
      model_keys[c.slot_index] = c.search_key;
      model_vals[c.slot_index] = c.slot_value;
      return r;
    end
    if (model_book) begin
      size = table_slots();
      mask = size - 1;
      pos = c.search_key[31:0] & mask;
      for (n = 0; n < size; n++) begin
        if (model_keys[pos] == EMPTY_KEY && model_vals[pos] == EMPTY_VALUE) break;
        if (model_keys[pos] == c.search_key) begin
          r.found = 1'b1;
          r.found_value = model_vals[pos];
          break;
        end
        pos = (pos + 1) & mask;
      end
    end
    return r;
  endfunction

  function automatic in_t noise_cmd();
    in_t c;
    c.op = 1'($urandom_range(1));
    c.slot_index = IDX_W'($urandom);
    c.search_key = rand_key();
    c.slot_value = VAL_W'($urandom);
    return c;
  endfunction

  // Mostly writes that build probe clusters and lookups of stored keys.
  function automatic in_t make_cmd();
    in_t              c;
    int unsigned      mask;
    int unsigned      sel;
    logic [KEY_W-1:0] k;
    mask = table_slots() - 1;
    sel = $urandom_range(99);
    c = noise_cmd();
    k = rand_key();
    if (sel < 45) begin
      c.op = OP_WRITE;
      if (sel < 30) begin
        c.search_key = k;
        c.slot_index = IDX_W'((k[31:0] + $urandom_range(2)) & mask);
      end else if (sel < 36) begin
        c.search_key = k;
      end else if (sel < 40) begin
        c.search_key = EMPTY_KEY;
        c.slot_value = EMPTY_VALUE;
        c.slot_index = IDX_W'(c.slot_index & mask);
      end else if (sel < 43) begin
        c.search_key = EMPTY_KEY;
        c.slot_index = IDX_W'($urandom_range(2) & mask);
      end else begin
        c.search_key = KEY_W'($urandom_range(15));
        c.slot_index = IDX_W'(c.search_key[31:0] & mask);
      end
      if (!(c.search_key == EMPTY_KEY && c.slot_value == EMPTY_VALUE)) begin
        key_pool.push_back(c.search_key);
        if (key_pool.size() > 64) void'(key_pool.pop_front());
      end
    end else begin
      c.op = OP_LOOKUP;
      if (key_pool.size() != 0 && sel < 80) begin
        c.search_key = key_pool[$urandom_range(key_pool.size() - 1)];
      end else if (key_pool.size() != 0 && sel < 88) begin
        c.search_key = key_pool[$urandom_range(key_pool.size() - 1)]
                       ^ (64'd1 << $urandom_range(63, 10));
      end else if (sel < 92) begin
        c.search_key = EMPTY_KEY;
      end
    end
    return c;
  endfunction

  task automatic send_cmd(input in_t c);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      cmd <= noise_cmd();
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(probe_table(c));
    n_sent++;
    if (c.op == OP_LOOKUP) n_lookups++;
  endtask

  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
    in_t c;
    c.op = op;
    c.slot_index = idx;
    c.search_key = key;
    c.slot_value = val;
    send_cmd(c);
  endtask

  // Hold start low until every outstanding result has arrived.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    cmd <= noise_cmd();
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_SIZE_LOG2) model_size_log2 = data;
    else if (idx == REG_BOOK_PRESENT) model_book = data[0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_wdata <= CFG_DATA_W'($urandom);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: found=%0b value=%02h",
                 $time, result.found, result.found_value);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (exp_r.found) n_hits++;
        if (result.found !== exp_r.found) begin
          $display("%0t found mismatch: expected %0b actual %0b",
                   $time, exp_r.found, result.found);
          n_errors++;
        end
        if (result.found_value !== exp_r.found_value) begin
          $display("%0t found_value mismatch: expected %02h actual %02h",
                   $time, exp_r.found_value, result.found_value);
          n_errors++;
        end
      end
    end
  end

  task automatic test_clear_and_defaults();
    send_item(OP_LOOKUP, '0, EMPTY_KEY, '0);
    send_item(OP_LOOKUP, '1, KEY_ONES, '1);
    set_reg(REG_BOOK_PRESENT, 4'd1);
    send_item(OP_LOOKUP, '0, EMPTY_KEY, '0);
    send_item(OP_LOOKUP, '0, KEY_ONES, '0);
  endtask

  task automatic test_write_results();
    send_item(OP_WRITE, 10'd0, KEY_ONES, 8'h00);
    send_item(OP_WRITE, 10'd1023, EMPTY_KEY, 8'h00);
    send_item(OP_WRITE, 10'd1, 64'h400, 8'h22);
    send_item(OP_WRITE, 10'd2, EMPTY_KEY, 8'h11);
  endtask

  task automatic test_probe_wraparound();
    send_item(OP_LOOKUP, '0, KEY_ONES, '0);
    send_item(OP_LOOKUP, '0, EMPTY_KEY, '0);
    send_item(OP_LOOKUP, '0, 64'h400, '0);
    send_item(OP_LOOKUP, '0, 64'h800, '0);
  endtask

  task automatic test_no_book();
    set_reg(REG_BOOK_PRESENT, 4'd0);
    send_item(OP_LOOKUP, '0, KEY_ONES, '0);
    send_item(OP_WRITE, 10'd3, 64'hFFFF_0000_0000_0003, 8'hFF);
    set_reg(REG_BOOK_PRESENT, 4'd1);
    send_item(OP_LOOKUP, '0, 64'hFFFF_0000_0000_0003, '0);
  endtask

  task automatic test_oversized_table();
    set_reg(REG_SIZE_LOG2, 4'd15);
    send_item(OP_LOOKUP, '0, KEY_ONES, '0);
    set_reg(REG_SIZE_LOG2, 4'd11);
    send_item(OP_LOOKUP, '0, EMPTY_KEY, '0);
  endtask

  task automatic test_single_slot();
    set_reg(REG_SIZE_LOG2, 4'd0);
    send_item(OP_LOOKUP, '0, KEY_ONES, '0);
    send_item(OP_LOOKUP, '0, 64'h5, '0);
    send_item(OP_LOOKUP, '0, EMPTY_KEY, '0);
  endtask

  task automatic test_exhausted_probe();
    set_reg(REG_SIZE_LOG2, 4'd1);
    send_item(OP_LOOKUP, '0, 64'h2, '0);
    set_reg(REG_SIZE_LOG2, 4'd2);
    send_item(OP_LOOKUP, '0, 64'h1000, '0);
  endtask

  task automatic test_empty_slot_stop();
    set_reg(REG_SIZE_LOG2, 4'd10);
    send_item(OP_WRITE, 10'd1, EMPTY_KEY, EMPTY_VALUE);
    send_item(OP_LOOKUP, '0, EMPTY_KEY, '0);
    send_item(OP_LOOKUP, '0, 64'h400, '0);
  endtask

  task automatic test_unused_registers();
    set_reg(REG_UNUSED_2, 4'd0);
    set_reg(REG_UNUSED_3, 4'd15);
    send_item(OP_LOOKUP, '0, KEY_ONES, '0);
  endtask

  task automatic test_random_traffic(input int idle_pct);
    int j;
    int n;
    sender_idle_pct = idle_pct;
    for (j = 0; j < 5; j++) begin
      if (j < 3) set_reg(REG_SIZE_LOG2, CFG_DATA_W'($urandom_range(4)));
      else if (j == 3) set_reg(REG_SIZE_LOG2, SIZE_LOG2_RESET);
      else set_reg(REG_SIZE_LOG2, CFG_DATA_W'($urandom_range(15, 11)));
      set_reg(REG_BOOK_PRESENT, ($urandom_range(9) != 0) ? 4'd1 : 4'd0);
      for (n = 0; n < ((j < 3) ? 130 : 40); n++) send_cmd(make_cmd());
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      model_keys[i] = EMPTY_KEY;
      model_vals[i] = EMPTY_VALUE;
    end
    model_size_log2 = SIZE_LOG2_RESET;
    model_book = 1'b0;
    sender_idle_pct = 0;
    n_sent = 0;
    n_lookups = 0;
    n_checked = 0;
    n_hits = 0;
    n_errors = 0;
    cycle_count = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_clear_and_defaults();
    test_write_results();
    test_probe_wraparound();
    test_no_book();
    test_oversized_table();
    test_single_slot();
    test_exhausted_probe();
    test_empty_slot_stop();
    test_unused_registers();
    test_random_traffic(10);
    test_random_traffic(47);
    test_random_traffic(0);

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d commands (%0d lookups); checked %0d results, %0d of them hits,",
             n_sent, n_lookups, n_checked, n_hits);
    $display("across table sizes 1 to 1024, saturated sizes and three sender idle mixes");
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
